/* design/assert_macros.svh */
// Assertion macros shared by the sigmoid interpolator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while reset is released.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked on every rising edge, reset cycles included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* design/sti_pkg.sv */
// Package for the sigmoid table interpolator: widths, types and the
// build-time functions that compute the sigmoid sample banks. No dependencies.
package sti_pkg;

    // Table geometry.
    localparam int SEGMENT_COUNT = 1280;
    localparam int STEP_SHIFT    = 5;

    localparam int SAMPLE_W   = 16;
    localparam int RESULT_W   = 16;
    localparam int IDX_W      = $clog2(SEGMENT_COUNT + 1);
    localparam int FRAC_W     = STEP_SHIFT;
    localparam int BANK_DEPTH = (SEGMENT_COUNT + 3) / 2;
    localparam int BANK_AW    = $clog2(BANK_DEPTH);
    localparam int ACC_W      = RESULT_W + STEP_SHIFT + 1;

    // Edges of the interpolated range in Q4.12 and the argument clamp.
    localparam int LOW_EDGE_Q  = -20480;
    localparam int HIGH_EDGE_Q = 20480;
    localparam int ARG_LIMIT_Q = 32768;

    localparam logic signed [SAMPLE_W-1:0] LOW_EDGE  = SAMPLE_W'(LOW_EDGE_Q);
    localparam logic signed [SAMPLE_W-1:0] HIGH_EDGE = SAMPLE_W'(HIGH_EDGE_Q);
    localparam logic [SAMPLE_W-1:0]        D_OFFSET  = SAMPLE_W'(-LOW_EDGE_Q);
    localparam logic [RESULT_W-1:0]        RESULT_MAX = '1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [RESULT_W-1:0]        t_result;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [FRAC_W-1:0]          t_frac;
    typedef logic [RESULT_W-1:0]        t_bank [BANK_DEPTH];

    // Where a sample falls relative to the interpolated range.
    typedef enum logic [1:0] {
        REGION_MID,
        REGION_LOW,
        REGION_HIGH
    } t_region;

    // Read request into the sample banks.
    typedef struct packed {
        logic rd_en;
        t_idx idx;
    } t_rom_req;

    // The two neighboring samples around a segment.
    typedef struct packed {
        t_result lo;
        t_result hi;
    } t_rom_pair;

    // Restoring shift-subtract division, used only while building the banks.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // exp(a) in Q32 for a in Q4.12 as a Taylor sum that stops at a zero term.
    function automatic logic [63:0] exp_q32(input int a);
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        sum  = 64'd1 << 32;
        term = 64'd1 << 32;
        done = 1'b0;
        for (int i = 1; i <= 64; i++) begin
            if (!done) begin
                term = udiv64(term * 64'(a), 64'(4096 * i));
                if (term == '0) begin
                    done = 1'b1;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return sum;
    endfunction

    // Sample k of the table, rounded to Q0.16 and capped at all ones.
    function automatic t_result sigmoid_entry(input int k);
        int          t;
        int          a;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] v;
        t = LOW_EDGE_Q + (k << STEP_SHIFT);
        a = (t < 0) ? -t : t;
        if (a > ARG_LIMIT_Q) begin
            a = ARG_LIMIT_Q;
        end
        e   = exp_q32(a);
        den = e + (64'd1 << 32);
        num = (t >= 0) ? (e << 16) : (64'd1 << 48);
        v   = udiv64(num + (den >> 1), den);
        if (v > 64'(RESULT_MAX)) begin
            v = 64'(RESULT_MAX);
        end
        return RESULT_W'(v);
    endfunction

    // One bank holds every other sample; entries past the table read as zero.
    function automatic t_bank build_bank(input logic odd);
        t_bank bank;
        int    k;
        for (int j = 0; j < BANK_DEPTH; j++) begin
            k = 2 * j + (odd ? 1 : 0);
            bank[j] = (k <= SEGMENT_COUNT) ? sigmoid_entry(k) : '0;
        end
        return bank;
    endfunction

endpackage

/* design/sti_rom.sv */
// Two-bank sample ROM of the sigmoid interpolator: returns the samples at a
// segment index and the next index, registered. Depends on sti_pkg.
module sti_rom
    import sti_pkg::*;
(
    input  logic      i_clk,
    input  t_rom_req  i_req,
    output t_rom_pair o_pair
);

    // Even samples in one bank, odd samples in the other.
    localparam t_bank EVEN_BANK = build_bank(1'b0);
    localparam t_bank ODD_BANK  = build_bank(1'b1);

    logic [BANK_AW-1:0]  even_addr;
    logic [BANK_AW-1:0]  odd_addr;
    logic [RESULT_W-1:0] r_even;
    logic [RESULT_W-1:0] r_odd;
    logic                r_swap;

    // An odd index takes its low sample from the odd bank and its high
    // sample from the next even entry.
    always_comb begin
        odd_addr  = BANK_AW'(i_req.idx[IDX_W-1:1]);
        even_addr = odd_addr + BANK_AW'(i_req.idx[0]);
    end

    // Registered bank reads.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_even <= EVEN_BANK[even_addr];
            r_odd  <= ODD_BANK[odd_addr];
            r_swap <= i_req.idx[0];
        end
    end

    // Put the two samples in index order.
    always_comb begin
        o_pair.lo = r_swap ? r_odd : r_even;
        o_pair.hi = r_swap ? r_even : r_odd;
    end

endmodule

/* design/sigmoid_table_interpolator.sv */
// Top level of the sigmoid table interpolator: input register, banked sample
// ROM and interpolating result register. Depends on sti_pkg and sti_rom.
//
// Usage: each input beat carries one signed Q4.12 sample on i_sample_in and
// is taken when i_valid is high and o_stall is low. Each beat yields exactly
// one output beat on o_sigmoid_out, unsigned Q0.16, taken when o_valid is high
// and i_stall is low. Samples below -5.0 give 0, samples above +5.0 give all
// ones; in between the result interpolates linearly between two samples.
// An accepted input beat passes the input register, registered bank read and
// result register on its way to its output beat. Throughput is one beat per
// cycle while the receiver does not stall; the two-bank ROM supplies both
// neighboring samples in a single read. A synchronous active-low reset
// empties all three stages; the sample banks are fixed and need no fill after
// reset. When the receiver stalls, the result holds and the stages behind it
// keep filling; o_stall rises only once all three stages hold beats.
`include "assert_macros.svh"

module sigmoid_table_interpolator
    import sti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_sample i_sample_in,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_sigmoid_out
);

    // Stage valids and their next values.
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic ready1, ready2, ready3;

    // Stage payloads.
    t_sample r_sample;
    t_region r_region;
    t_frac   r_frac;
    t_result r_result;

    // Combinational values of the address and result steps.
    logic [SAMPLE_W-1:0] rel_pos;
    logic [SAMPLE_W-1:0] idx_full;
    t_region             region;
    t_idx                idx;
    t_frac               frac;
    t_rom_req            rom_req;
    t_rom_pair           rom_pair;
    logic [FRAC_W:0]     w_lo;
    logic [ACC_W-1:0]    acc;
    t_result             n_result;

    // A stage can load when it is empty or its beat moves on.
    always_comb begin
        ready3 = !r_v3 || !i_stall;
        ready2 = !r_v2 || ready3;
        ready1 = !r_v1 || ready2;
        n_v1   = ready1 ? i_valid : r_v1;
        n_v2   = ready2 ? r_v1 : r_v2;
        n_v3   = ready3 ? r_v2 : r_v3;
    end

    assign o_stall = !ready1;
    assign o_valid = r_v3;
    assign o_sigmoid_out = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (ready1 && i_valid) begin
            r_sample <= i_sample_in;
        end
    end

    // Classify the sample and split its distance from -5.0 into index and
    // fraction. Past the last segment the last sample is read with no weight
    // on its neighbor.
    always_comb begin
        rel_pos  = r_sample + D_OFFSET;
        idx_full = rel_pos >> STEP_SHIFT;
        if (r_sample < LOW_EDGE) begin
            region = REGION_LOW;
        end else if (r_sample > HIGH_EDGE) begin
            region = REGION_HIGH;
        end else begin
            region = REGION_MID;
        end
        if (idx_full >= SAMPLE_W'(SEGMENT_COUNT)) begin
            idx  = IDX_W'(SEGMENT_COUNT);
            frac = '0;
        end else begin
            idx  = idx_full[IDX_W-1:0];
            frac = rel_pos[FRAC_W-1:0];
        end
        rom_req.rd_en = ready2 && r_v1;
        rom_req.idx   = idx;
    end

    sti_rom u_rom (
        .i_clk  (i_clk),
        .i_req  (rom_req),
        .o_pair (rom_pair)
    );

    // Side information that travels alongside the bank read.
    always_ff @(posedge i_clk) begin
        if (ready2 && r_v1) begin
            r_region <= region;
            r_frac   <= frac;
        end
    end

    // Weighted sum of the two samples, rounded to nearest.
    always_comb begin
        w_lo = (FRAC_W + 1)'(1 << STEP_SHIFT) - (FRAC_W + 1)'(r_frac);
        acc  = ACC_W'(rom_pair.lo) * ACC_W'(w_lo)
             + ACC_W'(rom_pair.hi) * ACC_W'(r_frac)
             + ACC_W'(1 << (STEP_SHIFT - 1));
        case (r_region)
            REGION_LOW:  n_result = '0;
            REGION_HIGH: n_result = RESULT_MAX;
            REGION_MID:  n_result = acc[STEP_SHIFT +: RESULT_W];
            default:     n_result = '0;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (ready3 && r_v2) begin
            r_result <= n_result;
        end
    end

    // A sample below the range always leaves as zero.
    `ASSERT_CLK_RST(a_low_gives_zero, i_clk, i_rst_n, (r_v2 && ready3 && r_region == REGION_LOW) |=> (o_valid && o_sigmoid_out == '0), "low sample did not give zero")

    // A sample above the range always leaves saturated.
    `ASSERT_CLK_RST(a_high_gives_max, i_clk, i_rst_n, (r_v2 && ready3 && r_region == REGION_HIGH) |=> (o_valid && o_sigmoid_out == RESULT_MAX), "high sample did not saturate")

    // A held input beat keeps its sample until the next stage frees up.
    `ASSERT_CLK_RST(a_input_holds, i_clk, i_rst_n, (r_v1 && !ready2) |=> $stable(r_sample), "held sample changed")

    // Reset leaves the pipeline empty and open.
    `ASSERT_CLK(a_reset_empty, i_clk, (!i_rst_n) |=> (!o_valid && !o_stall), "pipeline not empty after reset")

endmodule

/* test/sigmoid_checker.sv */
// Checker for the sigmoid table interpolator: watches both channels, predicts
// each result from the input beat and compares it. Depends on sti_pkg.
module sigmoid_checker
    import sti_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_stall,
    input  t_sample i_sample,
    input  logic    i_out_valid,
    input  logic    i_out_stall,
    input  t_result i_sigmoid,
    output int      o_fail_count,
    output int      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Sigmoid samples at the table grid points, from -5.0 upward.
    t_result sigmoid_points [SEGMENT_COUNT+1];
    // Predicted results still waiting for their output beat.
    t_result expected_sigmoid [$];

    // One grid point: exp(|t|) as a Q32 Taylor sum, then a rounded division.
    function automatic t_result grid_point(input int k);
        int              t;
        longint unsigned a;
        longint unsigned e;
        longint unsigned term;
        longint unsigned den;
        longint unsigned num;
        longint unsigned q;
        t = LOW_EDGE_Q + (k << STEP_SHIFT);
        a = (t < 0) ? -t : t;
        if (a > ARG_LIMIT_Q) begin
            a = ARG_LIMIT_Q;
        end
        e    = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int i = 1; i <= 64; i++) begin
            term = (term * a) / (64'd4096 * i);
            if (term == 0) begin
                break;
            end
            e = e + term;
        end
        den = e + (64'd1 << 32);
        num = (t >= 0) ? (e << 16) : (64'd1 << 48);
        q   = (num + den / 2) / den;
        if (q > 65535) begin
            q = 65535;
        end
        return t_result'(q);
    endfunction

    // Saturates outside [-5, +5] and interpolates between grid points inside.
    function automatic t_result sigmoid_of(input t_sample s);
        int          d;
        int          seg;
        int          frac;
        int unsigned acc;
        if (s < LOW_EDGE_Q) begin
            return '0;
        end
        if (s > HIGH_EDGE_Q) begin
            return '1;
        end
        d    = int'(s) - LOW_EDGE_Q;
        seg  = d >> STEP_SHIFT;
        frac = d & ((1 << STEP_SHIFT) - 1);
        if (seg >= SEGMENT_COUNT) begin
            return sigmoid_points[SEGMENT_COUNT];
        end
        acc = int'(sigmoid_points[seg]) * ((1 << STEP_SHIFT) - frac)
            + int'(sigmoid_points[seg+1]) * frac
            + (1 << (STEP_SHIFT - 1));
        return t_result'(acc >> STEP_SHIFT);
    endfunction

    // The grid is fixed, so it is built once before the first edge.
    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int k = 0; k <= SEGMENT_COUNT; k++) begin
            sigmoid_points[k] = grid_point(k);
        end
    end

    // Queue a prediction per input beat and compare each output beat with the oldest.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                expected_sigmoid.insert(expected_sigmoid.size(), sigmoid_of(i_sample));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_sigmoid.size() == 0) begin
                    $error("sigmoid_out: output beat %0d with no input beat pending",
                           i_sigmoid);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_sigmoid.pop_front();
                    if (i_sigmoid !== want) begin
                        $error("sigmoid_out mismatch: expected %0d, actual %0d",
                               want, i_sigmoid);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            o_pending = expected_sigmoid.size();
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench top for the sigmoid table interpolator: clock, reset, input and
// output idling, stimulus, verdict. Depends on sti_pkg, the DUT, sigmoid_checker.
module tb_top
    import sti_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic    i_clk       = 1'b0;
    logic    i_rst_n     = 1'b0;
    logic    i_valid     = 1'b0;
    logic    o_stall;
    t_sample i_sample_in = '0;
    logic    o_valid;
    logic    i_stall     = 1'b0;
    t_result o_sigmoid_out;

    int fail_count;
    int pending;
    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int stall_left   = 0;

    always #5 i_clk = ~i_clk;

    sigmoid_table_interpolator uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample_in   (i_sample_in),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_sigmoid_out (o_sigmoid_out)
    );

    sigmoid_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_sample     (i_sample_in),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_sigmoid    (o_sigmoid_out),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Sends one beat, sometimes after a burst of idle cycles with junk payload.
    task automatic send_beat(input t_sample s);
        int gap;
        if (send_idle_en && $urandom_range(0, 3) == 0) begin
            gap         = $urandom_range(1, 11);
            i_valid     = 1'b0;
            i_sample_in = t_sample'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_sample_in = s;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        @(negedge i_clk);
    endtask

    // Receiver stalls come in bursts, started at random while receiver idling is on.
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_left == 0 && recv_idle_en && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                i_stall    = 1'b1;
                stall_left = stall_left - 1;
            end else begin
                i_stall = 1'b0;
            end
        end
    end

    // Stimulus: edges and segment boundaries first, then random samples.
    initial begin
        t_sample edge_samples [$];
        t_sample s;
        int      pick;
        edge_samples = '{16'sh8000, 16'sh7FFF, -16'sd20481, -16'sd20480, -16'sd20479,
                         -16'sd20449, -16'sd20448, -16'sd1, 16'sd0, 16'sd1,
                         16'sd20447, 16'sd20448, 16'sd20479, 16'sd20480, 16'sd20481,
                         16'sh5555, 16'shAAAA, 16'sd4096, -16'sd4096, 16'sh0FFF};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        foreach (edge_samples[n]) begin
            send_beat(edge_samples[n]);
        end

        for (int n = 0; n < 800; n++) begin
            // Idling is switched per stretch of beats and is off for the last part.
            if (n % 100 == 0) begin
                send_idle_en = (n < 680) ? ($urandom_range(0, 3) != 0) : 1'b0;
                recv_idle_en = (n < 680) ? ($urandom_range(0, 3) != 0) : 1'b0;
            end
            pick = $urandom_range(0, 19);
            if (pick < 13) begin
                s = t_sample'($urandom_range(0, 40960) - 20480);
            end else if (pick < 16) begin
                s = t_sample'($urandom);
            end else if (pick < 18) begin
                s = t_sample'($urandom_range(0, 64) - 20512);
            end else begin
                s = t_sample'($urandom_range(0, 64) + 20416);
            end
            send_beat(s);
        end
        i_valid = 1'b0;

        // Drain, then keep running so that stray beats can still show.
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/sti_pkg.sv
design/sti_rom.sv
design/sigmoid_table_interpolator.sv
test/sigmoid_checker.sv
test/tb_top.sv
